/* sv/time_ordered_event_queue_core_defines.svh */
// assertion macros shared by the event queue rtl
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH

// implication checked in the same cycle
`define TOEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event queue check failed");

// implication checked in the next cycle
`define TOEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event queue sequencing check failed");

`endif

/* sv/toeq_pkg.sv */
`default_nettype none
package toeq_pkg;

  typedef enum logic [2:0] {
    ACT_PUT      = 3'd0,
    ACT_PUTBACK  = 3'd1,
    ACT_GET      = 3'd2,
    ACT_PEEK     = 3'd3,
    ACT_COMPRESS = 3'd4
  } action_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [7:0] PT_DELTA    = 8'd2;
  localparam logic [7:0] PT_ABSOLUTE = 8'd3;

  localparam int TIME_W = 48;

  typedef struct packed {
    action_t                   action;
    logic [15:0]               event_id;
    logic [7:0]                event_pair_type;
    logic [7:0]                event_pair;
    logic signed [31:0]        event_value;
    logic [TIME_W-1:0]         event_time_us;
    logic [7:0]                compress_factor;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [15:0]               out_id;
    logic [7:0]                out_pair_type;
    logic [7:0]                out_pair;
    logic signed [31:0]        out_value;
    logic [TIME_W-1:0]         out_time_us;
    logic [6:0]                removed_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0]               id;
    logic [7:0]                ptype;
    logic [7:0]                pair;
    logic [31:0]               value;
    logic [TIME_W-1:0]         time_us;
  } entry_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_PS_RD, ST_PS_CHK,
    ST_IA_RD, ST_IA_RD2, ST_IA_W1, ST_IA_W2,
    ST_PH_RD, ST_PH_W, ST_PH_W2,
    ST_GP_RD, ST_GP_OUT, ST_GP_W,
    ST_CP_RDT, ST_CP_RDH, ST_CP_DIV0, ST_CP_DIV, ST_CP_MUL,
    ST_CB_RD, ST_CB_CHK, ST_CB_NX, ST_CB_NX2,
    ST_CV_RD, ST_CV_CHK, ST_CV_PRD, ST_CV_PCHK, ST_CV_EVAL, ST_CV_UL,
    ST_FIN
  } state_t;

  function automatic logic is_valuator(entry_t e);
    return (e.value == 32'd0) || (e.ptype == PT_DELTA) || (e.ptype == PT_ABSOLUTE);
  endfunction

endpackage
`default_nettype wire

/* sv/toeq_ram.sv */
`default_nettype none
module toeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/time_ordered_event_queue_core.sv */
`default_nettype none
`include "time_ordered_event_queue_core_defines.svh"
// time ordered event queue: a pool of QUEUE_DEPTH events kept as a doubly
// linked list sorted by timestamp, head oldest.
// req channel (req_valid/req_stall/req) carries one command transaction:
// put sorted, putback at head, get, peek or compress. rsp channel
// (rsp_valid/rsp_stall/rsp) returns exactly one result per command.
// one command is worked on at a time; req_stall is high while busy.
// each link memory has a single read port, so a command is worked in steps:
//   put sorted compares entries one at a time from the tail and lands behind
//   the first one not later, or at the head; putback reads the free list and
//   writes the links; get and peek read the head, and get also frees it;
//   unused codes, overflow and empty results go straight to the result;
//   compress first reckons the threshold in the bit-serial divider, then
//   checks each base and the victims behind it, merges matching ids, finishes
// after reset a clearing pass over every entry chains the free list;
// req_stall stays high until it is done.
// a result waits in the output register while rsp_stall is high; the next
// command is still taken, and its result is held back until the slot frees.
module time_ordered_event_queue_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire toeq_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output toeq_pkg::rsp_t      rsp
);
  import toeq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  state_t state, state_next;
  logic [IW-1:0] head, head_next, tail, tail_next, fh, fh_next, cnt, cnt_next;
  logic [IW-1:0] p_idx, p_idx_next, v_idx, v_idx_next, vnx, vnx_next;
  logic [IW-1:0] pvv, pvv_next, fh_nx, fh_nx_next, nxt_p, nxt_p_next;
  logic [IW-1:0] init_idx, init_idx_next, rm_cnt, rm_cnt_next;
  entry_t base_ev, base_ev_next, v_ev, v_ev_next;
  logic [TIME_W-1:0] dq, dq_next;
  logic [IW-1:0] drem, drem_next;
  logic [5:0] div_cnt, div_cnt_next;
  logic [TIME_W+7:0] thr, thr_next;
  req_t cur, cur_next;
  rsp_t res, res_next, rsp_next;
  logic rsp_valid_next;

  logic ev_we, nx_we, pv_we;
  logic [IW-1:0] ev_waddr, nx_waddr, pv_waddr, ev_raddr, nx_raddr, pv_raddr;
  entry_t ev_wdata, ev_rd, cur_ev;
  logic [IW-1:0] nx_wdata, pv_wdata, nx_rd, pv_rd;

  logic [IW:0] trial;
  logic div_ge;
  logic [TIME_W-1:0] gap;
  logic [31:0] merged;
  logic [IW+6:0] rm_ext;

  toeq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ev_ram (
    .clk(clk), .we(ev_we), .waddr(ev_waddr[AW-1:0]), .wdata(ev_wdata),
    .raddr(ev_raddr[AW-1:0]), .rdata(ev_rd)
  );
  toeq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_nx_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr[AW-1:0]), .wdata(nx_wdata),
    .raddr(nx_raddr[AW-1:0]), .rdata(nx_rd)
  );
  toeq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_pv_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr[AW-1:0]), .wdata(pv_wdata),
    .raddr(pv_raddr[AW-1:0]), .rdata(pv_rd)
  );

  assign req_stall = (state != ST_IDLE);
  assign cur_ev = '{id: cur.event_id, ptype: cur.event_pair_type, pair: cur.event_pair,
                    value: cur.event_value, time_us: cur.event_time_us};
  assign trial  = {drem, dq[TIME_W-1]};
  assign div_ge = (trial >= {1'b0, cnt});
  assign gap    = (v_ev.time_us > base_ev.time_us) ? (v_ev.time_us - base_ev.time_us) : '0;
  assign merged = (base_ev.ptype == PT_ABSOLUTE) ? (base_ev.value + v_ev.value) : v_ev.value;
  assign rm_ext = {7'd0, rm_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      head      <= NULL_IDX;
      tail      <= NULL_IDX;
      fh        <= '0;
      cnt       <= '0;
      init_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      fh        <= fh_next;
      cnt       <= cnt_next;
      init_idx  <= init_idx_next;
      rsp_valid <= rsp_valid_next;
    end
    p_idx   <= p_idx_next;
    v_idx   <= v_idx_next;
    vnx     <= vnx_next;
    pvv     <= pvv_next;
    fh_nx   <= fh_nx_next;
    nxt_p   <= nxt_p_next;
    rm_cnt  <= rm_cnt_next;
    base_ev <= base_ev_next;
    v_ev    <= v_ev_next;
    dq      <= dq_next;
    drem    <= drem_next;
    div_cnt <= div_cnt_next;
    thr     <= thr_next;
    cur     <= cur_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next = state;
    head_next = head; tail_next = tail; fh_next = fh; cnt_next = cnt;
    p_idx_next = p_idx; v_idx_next = v_idx; vnx_next = vnx; pvv_next = pvv;
    fh_nx_next = fh_nx; nxt_p_next = nxt_p; init_idx_next = init_idx;
    rm_cnt_next = rm_cnt; base_ev_next = base_ev; v_ev_next = v_ev;
    dq_next = dq; drem_next = drem; div_cnt_next = div_cnt; thr_next = thr;
    cur_next = cur; res_next = res; rsp_next = rsp;
    rsp_valid_next = rsp_valid & rsp_stall;
    ev_we = 1'b0; ev_waddr = fh; ev_wdata = cur_ev; ev_raddr = p_idx;
    nx_we = 1'b0; nx_waddr = fh; nx_wdata = NULL_IDX; nx_raddr = p_idx;
    pv_we = 1'b0; pv_waddr = fh; pv_wdata = NULL_IDX; pv_raddr = p_idx;
    case (state)
      ST_INIT: begin
        nx_we = 1'b1; nx_waddr = init_idx; nx_wdata = init_idx + IW'(1);
        pv_we = 1'b1; pv_waddr = init_idx;
        if (init_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end else begin
          init_idx_next = init_idx + IW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cur_next = req;
          res_next = '0;
          rm_cnt_next = '0;
          state_next = ST_FIN;
          case (req.action)
            ACT_PUT: begin
              if (fh == NULL_IDX) begin
                res_next.status = STATUS_OVERFLOW;
              end else if (tail == NULL_IDX) begin
                state_next = ST_PH_RD;
              end else begin
                p_idx_next = tail;
                state_next = ST_PS_RD;
              end
            end
            ACT_PUTBACK: begin
              if (fh == NULL_IDX) begin
                res_next.status = STATUS_OVERFLOW;
              end else begin
                state_next = ST_PH_RD;
              end
            end
            ACT_GET, ACT_PEEK: begin
              if (head == NULL_IDX) begin
                res_next.status = STATUS_EMPTY;
              end else begin
                state_next = ST_GP_RD;
              end
            end
            ACT_COMPRESS: begin
              if (head != NULL_IDX) begin
                state_next = ST_CP_RDT;
              end
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      // backward walk from the tail
      ST_PS_RD: begin
        ev_raddr = p_idx; pv_raddr = p_idx;
        state_next = ST_PS_CHK;
      end
      ST_PS_CHK: begin
        if (ev_rd.time_us <= cur.event_time_us) begin
          state_next = ST_IA_RD;
        end else if (pv_rd == NULL_IDX) begin
          state_next = ST_PH_RD;
        end else begin
          p_idx_next = pv_rd;
          state_next = ST_PS_RD;
        end
      end
      ST_IA_RD: begin
        nx_raddr = fh;
        state_next = ST_IA_RD2;
      end
      ST_IA_RD2: begin
        fh_nx_next = nx_rd;
        nx_raddr = p_idx;
        state_next = ST_IA_W1;
      end
      ST_IA_W1: begin
        nxt_p_next = nx_rd;
        ev_we = 1'b1; ev_waddr = fh;
        nx_we = 1'b1; nx_waddr = fh; nx_wdata = nx_rd;
        pv_we = 1'b1; pv_waddr = fh; pv_wdata = p_idx;
        state_next = ST_IA_W2;
      end
      ST_IA_W2: begin
        nx_we = 1'b1; nx_waddr = p_idx; nx_wdata = fh;
        if (nxt_p != NULL_IDX) begin
          pv_we = 1'b1; pv_waddr = nxt_p; pv_wdata = fh;
        end else begin
          tail_next = fh;
        end
        fh_next = fh_nx;
        cnt_next = cnt + IW'(1);
        state_next = ST_FIN;
      end
      ST_PH_RD: begin
        nx_raddr = fh;
        state_next = ST_PH_W;
      end
      ST_PH_W: begin
        fh_nx_next = nx_rd;
        ev_we = 1'b1; ev_waddr = fh;
        nx_we = 1'b1; nx_waddr = fh; nx_wdata = head;
        pv_we = 1'b1; pv_waddr = fh;
        state_next = ST_PH_W2;
      end
      ST_PH_W2: begin
        if (head != NULL_IDX) begin
          pv_we = 1'b1; pv_waddr = head; pv_wdata = fh;
        end
        if (tail == NULL_IDX) begin
          tail_next = fh;
        end
        head_next = fh;
        fh_next = fh_nx;
        cnt_next = cnt + IW'(1);
        state_next = ST_FIN;
      end
      ST_GP_RD: begin
        ev_raddr = head; nx_raddr = head;
        state_next = ST_GP_OUT;
      end
      ST_GP_OUT: begin
        res_next.out_id        = ev_rd.id;
        res_next.out_pair_type = ev_rd.ptype;
        res_next.out_pair      = ev_rd.pair;
        res_next.out_value     = ev_rd.value;
        res_next.out_time_us   = ev_rd.time_us;
        state_next = ST_FIN;
        if (cur.action == ACT_GET) begin
          nx_we = 1'b1; nx_waddr = head; nx_wdata = fh;
          fh_next = head;
          cnt_next = cnt - IW'(1);
          if (tail == head) begin
            tail_next = NULL_IDX;
          end
          head_next = nx_rd;
          if (nx_rd != NULL_IDX) begin
            state_next = ST_GP_W;
          end
        end
      end
      ST_GP_W: begin
        pv_we = 1'b1; pv_waddr = head;
        state_next = ST_FIN;
      end
      // threshold: saturated span over count, times factor
      ST_CP_RDT: begin
        ev_raddr = tail;
        state_next = ST_CP_RDH;
      end
      ST_CP_RDH: begin
        dq_next = ev_rd.time_us;
        ev_raddr = head;
        state_next = ST_CP_DIV0;
      end
      ST_CP_DIV0: begin
        dq_next = (dq > ev_rd.time_us) ? (dq - ev_rd.time_us) : '0;
        drem_next = '0;
        div_cnt_next = '0;
        state_next = ST_CP_DIV;
      end
      ST_CP_DIV: begin
        drem_next = div_ge ? IW'(trial - {1'b0, cnt}) : trial[IW-1:0];
        dq_next = {dq[TIME_W-2:0], div_ge};
        div_cnt_next = div_cnt + 6'd1;
        if (div_cnt == 6'(TIME_W - 1)) begin
          state_next = ST_CP_MUL;
        end
      end
      ST_CP_MUL: begin
        thr_next = {8'd0, dq} * {{TIME_W{1'b0}}, cur.compress_factor};
        p_idx_next = head;
        state_next = ST_CB_RD;
      end
      ST_CB_RD: begin
        ev_raddr = p_idx; nx_raddr = p_idx;
        state_next = (p_idx == NULL_IDX) ? ST_FIN : ST_CB_CHK;
      end
      ST_CB_CHK: begin
        base_ev_next = ev_rd;
        if (is_valuator(ev_rd)) begin
          v_idx_next = nx_rd;
          state_next = ST_CV_RD;
        end else begin
          p_idx_next = nx_rd;
          state_next = ST_CB_RD;
        end
      end
      // base link is read again since merges may have changed it
      ST_CB_NX: begin
        nx_raddr = p_idx;
        state_next = ST_CB_NX2;
      end
      ST_CB_NX2: begin
        p_idx_next = nx_rd;
        state_next = ST_CB_RD;
      end
      ST_CV_RD: begin
        ev_raddr = v_idx; nx_raddr = v_idx; pv_raddr = v_idx;
        state_next = (v_idx == NULL_IDX) ? ST_CB_NX : ST_CV_CHK;
      end
      ST_CV_CHK: begin
        v_ev_next = ev_rd;
        vnx_next = nx_rd;
        pvv_next = pv_rd;
        if (!is_valuator(ev_rd)) begin
          state_next = ST_CB_NX;
        end else if (pv_rd != p_idx) begin
          state_next = ST_CV_PRD;
        end else begin
          state_next = ST_CV_EVAL;
        end
      end
      ST_CV_PRD: begin
        ev_raddr = pvv;
        state_next = ST_CV_PCHK;
      end
      ST_CV_PCHK: begin
        state_next = (ev_rd.time_us != v_ev.time_us) ? ST_CB_NX : ST_CV_EVAL;
      end
      ST_CV_EVAL: begin
        if ((cur.compress_factor != 8'd0) && ({8'd0, gap} > thr)) begin
          state_next = ST_CB_NX;
        end else if (v_ev.id == base_ev.id) begin
          base_ev_next.value = merged;
          ev_we = 1'b1; ev_waddr = p_idx;
          ev_wdata = base_ev;
          ev_wdata.value = merged;
          nx_we = 1'b1; nx_waddr = pvv; nx_wdata = vnx;
          state_next = ST_CV_UL;
        end else begin
          v_idx_next = vnx;
          state_next = ST_CV_RD;
        end
      end
      ST_CV_UL: begin
        if (tail == v_idx) begin
          tail_next = pvv;
        end else begin
          pv_we = 1'b1; pv_waddr = vnx; pv_wdata = pvv;
        end
        nx_we = 1'b1; nx_waddr = v_idx; nx_wdata = fh;
        fh_next = v_idx;
        cnt_next = cnt - IW'(1);
        rm_cnt_next = rm_cnt + IW'(1);
        v_idx_next = vnx;
        state_next = ST_CV_RD;
      end
      ST_FIN: begin
        if (!(rsp_valid && rsp_stall)) begin
          rsp_next = res;
          rsp_next.removed_count = rm_ext[6:0];
          rsp_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `TOEQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= NULL_IDX)
  `TOEQ_ASSERT_IMP(a_empty_match, state == ST_IDLE, (head == NULL_IDX) == (cnt == '0))
  `TOEQ_ASSERT_IMP(a_tail_match, state == ST_IDLE, (head == NULL_IDX) == (tail == NULL_IDX))
  `TOEQ_ASSERT_IMP(a_full_match, state == ST_IDLE, (fh == NULL_IDX) == (cnt == NULL_IDX))
  `TOEQ_ASSERT_NXT(a_busy_after_take, req_valid && !req_stall, state != ST_IDLE)
endmodule
`default_nettype wire

/* tb/toeq_checker.sv */
`timescale 1ns / 1ps
module toeq_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_stall,
  input  wire toeq_pkg::req_t req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_stall,
  input  wire toeq_pkg::rsp_t rsp,
  output int                  fail_count,
  output int                  pending
);
  import toeq_pkg::*;

  localparam int NIL = QUEUE_DEPTH;

  entry_t pool [QUEUE_DEPTH];
  int     nxt [QUEUE_DEPTH];
  int     prv [QUEUE_DEPTH];
  int     head_q, tail_q, free_q, count_q;
  rsp_t   awaited [$];
  int     merges_seen, overflows_seen, empties_seen;

  function automatic bit valuator(int n);
    return pool[n].value == 0 || pool[n].ptype == PT_DELTA || pool[n].ptype == PT_ABSOLUTE;
  endfunction

  function automatic int take_slot();
    int n;
    n = free_q;
    if (n >= NIL) return NIL;
    free_q = nxt[n];
    nxt[n] = NIL;
    count_q++;
    return n;
  endfunction

  function automatic void drop_slot(int n);
    nxt[n] = free_q;
    prv[n] = NIL;
    free_q = n;
    count_q--;
  endfunction

  function automatic logic [1:0] insert_head(entry_t e);
    int n;
    n = take_slot();
    if (n >= NIL) return STATUS_OVERFLOW;
    pool[n] = e;
    nxt[n] = head_q;
    prv[n] = NIL;
    if (head_q < NIL) prv[head_q] = n;
    head_q = n;
    if (tail_q >= NIL) tail_q = n;
    return STATUS_OK;
  endfunction

  function automatic logic [1:0] insert_sorted(entry_t e);
    int p, n;
    for (p = tail_q; p < NIL; p = prv[p]) begin
      if (pool[p].time_us <= e.time_us) begin
        n = take_slot();
        if (n >= NIL) return STATUS_OVERFLOW;
        pool[n] = e;
        nxt[n] = nxt[p];
        prv[n] = p;
        if (nxt[p] < NIL) prv[nxt[p]] = n;
        else tail_q = n;
        nxt[p] = n;
        return STATUS_OK;
      end
    end
    return insert_head(e);
  endfunction

  function automatic int coalesce(logic [7:0] factor);
    int start, b, v, vn, p;
    logic [63:0] span, limit, gap;
    start = count_q;
    if (head_q >= NIL) return 0;
    span = (pool[tail_q].time_us > pool[head_q].time_us) ?
           64'(pool[tail_q].time_us - pool[head_q].time_us) : 64'd0;
    limit = (span / 64'(count_q)) * 64'(factor);
    for (b = head_q; b < NIL; b = nxt[b]) begin
      if (!valuator(b)) continue;
      for (v = nxt[b]; v < NIL; v = vn) begin
        vn = nxt[v];
        if (!valuator(v)) break;
        p = prv[v];
        if (p != b && pool[p].time_us != pool[v].time_us) break;
        gap = (pool[v].time_us > pool[b].time_us) ?
              64'(pool[v].time_us - pool[b].time_us) : 64'd0;
        if (factor != 0 && gap > limit) break;
        if (pool[v].id == pool[b].id) begin
          if (pool[b].ptype == PT_ABSOLUTE) pool[b].value = pool[b].value + pool[v].value;
          else pool[b].value = pool[v].value;
          nxt[p] = nxt[v];
          if (tail_q == v) tail_q = p;
          else prv[nxt[v]] = p;
          drop_slot(v);
          merges_seen++;
        end
      end
    end
    return start - count_q;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t   o;
    entry_t e;
    int     h;
    o = '0;
    e = '{id: r.event_id, ptype: r.event_pair_type, pair: r.event_pair,
          value: r.event_value, time_us: r.event_time_us};
    case (r.action)
      ACT_PUT:     o.status = insert_sorted(e);
      ACT_PUTBACK: o.status = insert_head(e);
      ACT_GET, ACT_PEEK: begin
        if (head_q >= NIL) begin
          o.status = STATUS_EMPTY;
        end else begin
          h = head_q;
          o.out_id = pool[h].id;
          o.out_pair_type = pool[h].ptype;
          o.out_pair = pool[h].pair;
          o.out_value = pool[h].value;
          o.out_time_us = pool[h].time_us;
          if (r.action == ACT_GET) begin
            head_q = nxt[h];
            if (head_q < NIL) prv[head_q] = NIL;
            if (tail_q == h) tail_q = NIL;
            drop_slot(h);
          end
        end
      end
      ACT_COMPRESS: o.removed_count = 7'(coalesce(r.compress_factor));
      default: ;
    endcase
    if (o.status == STATUS_OVERFLOW) overflows_seen++;
    if (o.status == STATUS_EMPTY) empties_seen++;
    return o;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        nxt[i] = i + 1;
        prv[i] = NIL;
      end
      head_q = NIL;
      tail_q = NIL;
      free_q = 0;
      count_q = 0;
      awaited.delete();
      fail_count <= 0;
      merges_seen = 0;
      overflows_seen = 0;
      empties_seen = 0;
    end else begin
      if (req_valid && !req_stall) awaited.push_back(predict_result(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = awaited.pop_front();
          if (rsp !== want) begin
            if (rsp.status !== want.status)
              $error("status exp %0d got %0d", want.status, rsp.status);
            if (rsp.out_id !== want.out_id)
              $error("out_id exp %0d got %0d", want.out_id, rsp.out_id);
            if (rsp.out_pair_type !== want.out_pair_type)
              $error("out_pair_type exp %0d got %0d", want.out_pair_type, rsp.out_pair_type);
            if (rsp.out_pair !== want.out_pair)
              $error("out_pair exp %0d got %0d", want.out_pair, rsp.out_pair);
            if (rsp.out_value !== want.out_value)
              $error("out_value exp %0d got %0d", want.out_value, rsp.out_value);
            if (rsp.out_time_us !== want.out_time_us)
              $error("out_time_us exp %0d got %0d", want.out_time_us, rsp.out_time_us);
            if (rsp.removed_count !== want.removed_count)
              $error("removed_count exp %0d got %0d", want.removed_count,
                     rsp.removed_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/time_ordered_event_queue_core_tb.sv */
`timescale 1ns / 1ps
module time_ordered_event_queue_core_tb;
  import toeq_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   fail_count, pending;
  int   send_idle_pct = 24, recv_idle_pct = 59;
  int   idle_cycles = 0, sent = 0;
  logic [47:0] clock_us = 48'd1000;
  logic [15:0] id_pool [4] = '{16'd0, 16'd7, 16'd65535, 16'd300};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  time_ordered_event_queue_core #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  toeq_checker #(.QUEUE_DEPTH(DEPTH)) u_chk (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (!rst) rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // one transaction, with random idle cycles ahead of it
  task automatic issue(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  function automatic req_t make_event(action_t a, logic [15:0] id, logic [7:0] pt,
                                      logic [31:0] val, logic [47:0] t);
    req_t r;
    r = '0;
    r.action = a;
    r.event_id = id;
    r.event_pair_type = pt;
    r.event_pair = 8'($urandom);
    r.event_value = val;
    r.event_time_us = t;
    return r;
  endfunction

  function automatic req_t random_item();
    req_t r;
    int   k;
    logic [127:0] raw;
    k = $urandom_range(99);
    clock_us = clock_us + 48'($urandom_range(40));
    r = make_event(ACT_PUT, id_pool[2'($urandom_range(3))], 8'($urandom_range(1, 4)),
                   ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom),
                   clock_us - 48'($urandom_range(30)));
    r.compress_factor = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
    if (k < 5) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_t)-1:0];
      r.action = action_t'(3'($urandom_range(7)));
    end else if (k < 45) r.action = ACT_PUT;
    else if (k < 52) r.action = ACT_PUTBACK;
    else if (k < 80) r.action = ACT_GET;
    else if (k < 88) r.action = ACT_PEEK;
    else r.action = ACT_COMPRESS;
    if (k >= 5 && k < 8) r.event_time_us = 48'({$urandom, $urandom});
    return r;
  endfunction

  initial begin
    req_t r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, field extremes, pool overflow, coalescing
    issue(make_event(ACT_GET, 0, 0, 0, 0));
    issue(make_event(ACT_PEEK, 0, 0, 0, 0));
    issue(make_event(ACT_COMPRESS, 0, 0, 0, 0));
    issue(make_event(ACT_PUT, 16'hffff, 8'hff, 32'h8000_0000, 48'hffff_ffff_ffff));
    issue(make_event(ACT_PUT, 16'h0000, 8'h00, 32'h7fff_ffff, 48'h0));
    issue(make_event(ACT_PUTBACK, 16'h1234, PT_DELTA, 32'hffff_ffff, 48'h5));
    r = make_event(ACT_PEEK, 0, 0, 0, 0);
    r.event_pair = 8'hff;
    issue(r);
    issue(make_event(action_t'(3'd5), 16'hffff, 8'hff, 32'hffff_ffff, 48'hffff_ffff_ffff));
    issue(make_event(action_t'(3'd7), 0, 0, 0, 0));
    repeat (3) issue(make_event(ACT_GET, 0, 0, 0, 0));
    for (int i = 0; i < DEPTH + 2; i++)
      issue(make_event((i % 2) ? ACT_PUTBACK : ACT_PUT, 16'(i % 3),
                       (i % 4 == 0) ? PT_ABSOLUTE : PT_DELTA, 32'(i * 5),
                       48'(i / 4)));
    r = make_event(ACT_COMPRESS, 0, 0, 0, 0);
    r.compress_factor = 8'hff;
    issue(r);
    r.compress_factor = 8'd0;
    issue(r);
    for (int i = 0; i < DEPTH; i++) issue(make_event(ACT_GET, 0, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 24 : 0;
      for (int i = 0; i < 450; i++) issue(random_item());
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d commands; merges %0d, overflows %0d, empty reads %0d",
             sent, u_chk.merges_seen, u_chk.overflows_seen, u_chk.empties_seen);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
